// ===== hw/rtl/bstc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bstc_pkg
// Types, codes and word lists shared by the token classifier modules.
// ---------------------------------------------------------------------------
package bstc_pkg;

  localparam int LineMaxDefault = 4096;
  localparam int WordMaxDefault = 15;
  localparam int WordCap = 31;

  typedef struct packed {
    logic [20:0] code_point;
    logic        end_of_line;
  } in_word_t;

  typedef struct packed {
    logic [11:0] span_start;
    logic [12:0] span_end;
    logic [2:0]  span_style;
    logic        last_of_run;
  } out_word_t;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_APOS, MODE_COMMENT, MODE_PREPROC, MODE_STRING, MODE_NUMBER, MODE_WORD
  } mode_t;

  typedef enum logic [2:0] {
    ST_COMMENT = 3'd0, ST_PREPROC = 3'd1, ST_STRING = 3'd2,
    ST_KEYWORD = 3'd3, ST_TYPE = 3'd4, ST_IDENT = 3'd5
  } style_t;

  typedef logic [WordCap*8-1:0] word_text_t;

  localparam int NumKeywords = 111;
  localparam int NumTypes = 26;

  // Words are packed with the first character in the low byte, padded with zeros.
  function automatic word_text_t pack_word(input string s);
    word_text_t w;
    w = '0;
    for (int i = 0; i < s.len(); i++) w[i*8 +: 8] = s[i];
    return w;
  endfunction

  function automatic string keyword_at(input int k);
    string l [NumKeywords];
    l = '{"addhandler","addressof","alias","and","andalso","ansi","as","assembly",
      "auto","byref","byval","call","case","catch","class","const",
      "declare","default","delegate","dim","directcast","do",
      "each","else","elseif","end","enum","erase","error",
      "event","exit","false","finally","for","friend","function","get",
      "gettype","gosub","goto","handles","if","implements","imports","in",
      "inherits","interface","is","let","lib","like",
      "loop","me","mod","module","mustinherit","mustoverride","mybase","myclass",
      "namespace","new","next","not","nothing","notinheritable","notoverridable",
      "on","option","optional","or","orelse","overloads","overridable","overrides",
      "paramarray","preserve","private","property","protected","public","raiseevent",
      "readonly","redim","rem","removehandler","resume","return","select","set",
      "shadows","shared","static","step","stop","structure",
      "sub","synclock","then","throw","to","true","try","typeof",
      "unicode","until","when","while","with","withevents","writeonly","xor"};
    return l[k];
  endfunction

  function automatic string type_at(input int k);
    string l [NumTypes];
    l = '{"boolean","byte","char","cbool",
      "cbyte","cchar","cdate","cdec","cdbl","cint","clng","cobj","cshort","csng",
      "cstr","ctype","date","decimal","double","integer","long","object","short",
      "single","string","variant"};
    return l[k];
  endfunction

  function automatic logic is_digit(input logic [20:0] c);
    return c >= 21'h30 && c <= 21'h39;
  endfunction

  function automatic logic is_alpha(input logic [20:0] c);
    return (c >= 21'h61 && c <= 21'h7a) || (c >= 21'h41 && c <= 21'h5a);
  endfunction

endpackage

// ===== hw/rtl/basic_syntax_token_classifier_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// basic_syntax_token_classifier_core
// Streaming lexer for BASIC source lines: one character in, up to two spans out.
// ---------------------------------------------------------------------------
// Usage:
//   in / in_valid / in_ready carry one character word with its end-of-line mark.
//   out / out_valid / out_ready carry span words (start, end, style, last).
//   Each character is classified in the cycle it is accepted; its spans land in
//   a two-entry result register and appear in the next cycle.
//   Throughput: one character per cycle while the receiver takes every span.
//   A character that yields two spans (a word or number ended by a character
//   that itself opens a token ending at the line end) fills both result slots,
//   so input stalls while the first span drains.
//   The first span is valid in the cycle after its character is accepted.
//   The rate is set by the output register: a new character is taken whenever
//   the register will be empty after this cycle's transfer.
//   Reset: mode goes idle, column and word length clear; no spans are pending.
//   Receiver stall: spans hold in the result register and in_ready drops until
//   they drain; nothing is lost.
// ---------------------------------------------------------------------------
module basic_syntax_token_classifier_core #(
  parameter int LINE_MAX = bstc_pkg::LineMaxDefault,
  parameter int WORD_MAX = bstc_pkg::WordMaxDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  bstc_pkg::in_word_t  in,
  input  logic                in_valid,
  output logic                in_ready,
  output bstc_pkg::out_word_t out,
  output logic                out_valid,
  input  logic                out_ready
);
  import bstc_pkg::*;

  localparam int ColW = $clog2(LINE_MAX + 1);
  localparam int LenW = $clog2(WORD_MAX + 2);
  localparam int IdxW = $clog2(WORD_MAX);

  // Lexer state
  mode_t               mode;
  logic [ColW-1:0]     column;
  logic [ColW-1:0]     token_start;
  logic [WORD_MAX*7-1:0] word_chars;
  logic [LenW-1:0]     word_length;

  // Result register: up to two spans, slot 0 first
  out_word_t           slot [2];
  logic [1:0]          count;

  logic        take;
  logic [20:0] c;
  logic        eol;
  logic [ColW-1:0] pos, here, endc;
  logic        used;
  mode_t       mode_next;
  logic [ColW-1:0] start_next;
  logic [WORD_MAX*7-1:0] chars_next;
  logic [LenW-1:0] len_next;
  logic [1:0]  n;
  out_word_t   r0, r1;
  logic [2:0]  wstyle;
  logic [6:0]  lc;
  logic        is_word, is_suffix, is_alnum;

  assign c   = in.code_point;
  assign eol = in.end_of_line;
  assign in_ready = (count == 2'd0) || (count == 2'd1 && out_ready);
  assign take = in_valid && in_ready;

  assign pos  = (column < ColW'(LINE_MAX)) ? column : ColW'(LINE_MAX - 1);
  assign here = column;
  assign endc = here + ((here < ColW'(LINE_MAX)) ? ColW'(1) : ColW'(0));

  assign is_alnum  = is_alpha(c) || is_digit(c);
  assign is_word   = is_alnum || c == 21'h5f;
  assign is_suffix = c == 21'h24 || c == 21'h26 || c == 21'h21 || c == 21'h40 ||
                     c == 21'h25 || c == 21'h23;
  assign lc = (c >= 21'h41 && c <= 21'h5a) ? 7'(c[6:0] + 7'd32) : c[6:0];

  bstc_word_match #(.WORD_MAX(WORD_MAX)) u_match (
    .chars (chars_next),
    .length(len_next),
    .style (wstyle)
  );

  function automatic out_word_t mk(input logic [ColW-1:0] s, input logic [ColW-1:0] e,
                                   input logic [2:0] st);
    out_word_t w;
    w.span_start  = 12'(s);
    w.span_end    = 13'(e);
    w.span_style  = st;
    w.last_of_run = 1'b0;
    return w;
  endfunction

  always_comb begin
    mode_next  = mode;
    start_next = token_start;
    chars_next = word_chars;
    len_next   = word_length;
    used = 1'b1;
    n  = 2'd0;
    r0 = '0;
    r1 = '0;
    // Word characters are appended before the style is looked up; a new word
    // opens from idle or right after a number that this character ends
    if ((mode == MODE_WORD && is_word) ||
        ((mode == MODE_IDLE || (mode == MODE_NUMBER && !is_alnum && c != 21'h2e)) &&
         (is_alpha(c) || c == 21'h5f))) begin
      if (mode != MODE_WORD) len_next = '0;
      if (len_next < LenW'(WORD_MAX)) chars_next[IdxW'(len_next)*7 +: 7] = lc;
      if (len_next < LenW'(WORD_MAX + 1)) len_next = len_next + LenW'(1);
    end
    case (mode)
      MODE_APOS: begin
        mode_next = (c == 21'h24) ? MODE_PREPROC : MODE_COMMENT;
        if (eol) begin
          n = 2'd1;
          r0 = mk(token_start, endc, (c == 21'h24) ? ST_PREPROC : ST_COMMENT);
        end
      end
      MODE_COMMENT, MODE_PREPROC: begin
        if (eol) begin
          n = 2'd1;
          r0 = mk(token_start, endc, (mode == MODE_PREPROC) ? ST_PREPROC : ST_COMMENT);
        end
      end
      MODE_STRING: begin
        if (c == 21'h22 || eol) begin
          n = 2'd1;
          r0 = mk(token_start, endc, ST_STRING);
          if (c == 21'h22) mode_next = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (is_alnum || c == 21'h2e) begin
          if (eol) begin
            n = 2'd1;
            r0 = mk(token_start, endc, ST_IDENT);
          end
        end else begin
          n = 2'd1;
          r0 = mk(token_start, here, ST_IDENT);
          mode_next = MODE_IDLE;
          used = 1'b0;
        end
      end
      MODE_WORD: begin
        if (is_word) begin
          if (eol) begin
            n = 2'd1;
            r0 = mk(token_start, endc, wstyle);
          end
        end else if (is_suffix) begin
          n = 2'd1;
          r0 = mk(token_start, endc, wstyle);
          mode_next = MODE_IDLE;
        end else begin
          n = 2'd1;
          r0 = mk(token_start, here, wstyle);
          mode_next = MODE_IDLE;
          used = 1'b0;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
        used = 1'b0;
      end
    endcase
    if (!used) begin
      // Start a new token at this character; a second span only arises at line end
      start_next = pos;
      r1 = mk(pos, endc, ST_IDENT);
      if (c == 21'h27) begin
        r1.span_style = ST_COMMENT;
        if (!eol) mode_next = MODE_APOS;
      end else if (c == 21'h22) begin
        r1.span_style = ST_STRING;
        if (!eol) mode_next = MODE_STRING;
      end else if (is_digit(c)) begin
        if (!eol) mode_next = MODE_NUMBER;
      end else if (is_alpha(c) || c == 21'h5f) begin
        r1.span_style = wstyle;
        if (!eol) mode_next = MODE_WORD;
      end
      if (eol && (c == 21'h27 || c == 21'h22 || is_digit(c) || is_alpha(c) ||
                  c == 21'h5f)) begin
        if (n == 2'd0) r0 = r1;
        n = n + 2'd1;
      end
    end
    if (n == 2'd1) r0.last_of_run = 1'b1;
    else r1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      column      <= '0;
      token_start <= '0;
      word_length <= '0;
    end else if (take) begin
      token_start <= start_next;
      word_chars  <= chars_next;
      if (eol) begin
        mode        <= MODE_IDLE;
        column      <= '0;
        word_length <= '0;
      end else begin
        mode        <= mode_next;
        word_length <= len_next;
        if (column < ColW'(LINE_MAX)) column <= column + ColW'(1);
      end
    end
  end

  // Result register: drain slot 0, shift slot 1 down, load new spans
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (take) begin
        count <= n;
        slot[0] <= r0;
        slot[1] <= r1;
      end else if (out_valid && out_ready) begin
        count <= count - 2'd1;
        slot[0] <= slot[1];
      end
    end
  end

  assign out_valid = count != 2'd0;
  assign out       = slot[0];

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("result count out of range");
  a_take_empty: assert property (@(posedge clk) disable iff (rst)
      take |-> (count == 2'd0 || (count == 2'd1 && out_ready)))
    else $error("item taken over pending span");
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
      (count == 2'd1) |-> out.last_of_run)
    else $error("final span lacks last flag");
  a_col_sat: assert property (@(posedge clk) disable iff (rst)
      column <= ColW'(LINE_MAX))
    else $error("column beyond line maximum");
`endif

endmodule

// ===== hw/rtl/bstc_word_match.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bstc_word_match
// Compares the held word, completed by an optional new character, against the
// fixed keyword and type lists in parallel and returns its style.
// ---------------------------------------------------------------------------
module bstc_word_match #(
  parameter int WORD_MAX = bstc_pkg::WordMaxDefault
) (
  input  logic [WORD_MAX*7-1:0]       chars,
  input  logic [$clog2(WORD_MAX+2)-1:0] length,
  output logic [2:0]                  style
);
  import bstc_pkg::*;

  localparam int LenW = $clog2(WORD_MAX + 2);

  word_text_t text;
  logic       kw_hit;
  logic       ty_hit;

  always_comb begin
    text = '0;
    for (int i = 0; i < WORD_MAX; i++) begin
      if (LenW'(i) < length) text[i*8 +: 8] = {1'b0, chars[i*7 +: 7]};
    end
  end

  always_comb begin
    kw_hit = 1'b0;
    ty_hit = 1'b0;
    if (length <= LenW'(WORD_MAX)) begin
      for (int k = 0; k < NumKeywords; k++) begin
        if (keyword_at(k).len() <= WORD_MAX && text == pack_word(keyword_at(k))
            && length == LenW'(keyword_at(k).len())) kw_hit = 1'b1;
      end
      for (int k = 0; k < NumTypes; k++) begin
        if (type_at(k).len() <= WORD_MAX && text == pack_word(type_at(k))
            && length == LenW'(type_at(k).len())) ty_hit = 1'b1;
      end
    end
    if (kw_hit) style = ST_KEYWORD;
    else if (ty_hit) style = ST_TYPE;
    else style = ST_IDENT;
  end

endmodule
